// File: rtl/core/sisp_pkg.sv
// Package with the item types, cell control struct and sum helper for the pair sorter.
package sisp_pkg;

    localparam int PIP_W = 3;
    localparam int SUM_W = PIP_W + 1;

    typedef logic [PIP_W-1:0] pip_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        pip_t first;
        pip_t second;
    } entry_t;

    typedef struct packed {
        pip_t pip_first;
        pip_t pip_second;
        logic batch_end;
    } in_item_t;

    typedef struct packed {
        pip_t out_first;
        pip_t out_second;
        logic out_last;
        logic overflowed;
    } out_item_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   shift_out;
        entry_t new_entry;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    function automatic sum_t pair_sum(entry_t e);
        pair_sum = {1'b0, e.first} + {1'b0, e.second};
    endfunction

endpackage

// File: rtl/core/stable_insertion_sort_pairs_by_sum_unit.sv
// Top level of the stable pair sorter: a chain of insertion cells and its controller.
//
// Usage: pairs arrive on the input channel (in_valid/in_ready, payload in_item)
// and are kept in ascending order of pip_first + pip_second; a pair goes after
// every stored pair with an equal or smaller sum. Each accepted item is placed
// in the chain in the cycle it is accepted, because every cell compares its own
// sum with the arriving pair at once and the larger ones step one cell right.
// While loading, one item is taken every cycle. An item with batch_end set is
// inserted too, then the sorted batch leaves on the output channel
// (out_valid/out_ready, payload out_item) from the head cell, one result per
// cycle while out_ready is high as the chain shifts left; the first result is
// offered in the cycle after the batch-end item is accepted, and in_ready is
// low while the batch drains. The last result carries out_last.
// When the chain is full, arriving items are dropped and every result of that
// batch carries overflowed. A stalled receiver simply holds the head result
// and the chain in place. Reset empties the chain and returns to loading.
module stable_insertion_sort_pairs_by_sum_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sisp_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sisp_pkg::out_item_t out_item
);
    import sisp_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       overflow_reg;
    logic       overflow_next;
    cell_ctrl_t ctrl;

    logic                cell_valid [CAPACITY];
    entry_t              cell_entry [CAPACITY];
    logic                cell_ins   [CAPACITY];

    logic in_accept;
    logic out_accept;
    logic full;

    assign in_ready   = (state_reg == ST_LOAD);
    assign out_valid  = (state_reg == ST_DRAIN);
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;

    // The chain is packed from the head, so the tail cell tells whether it is full.
    assign full = cell_valid[CAPACITY-1];

    assign ctrl.insert              = in_accept && !full;
    assign ctrl.shift_out           = out_accept;
    assign ctrl.new_entry.first     = in_item.pip_first;
    assign ctrl.new_entry.second    = in_item.pip_second;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic   left_valid;
            entry_t left_entry;
            logic   left_ins;
            logic   right_valid;
            entry_t right_entry;

            if (gi == 0)
            begin : g_head
                assign left_valid = 1'b0;
                assign left_entry = ctrl.new_entry;
                assign left_ins   = 1'b0;
            end
            else
            begin : g_body
                assign left_valid = cell_valid[gi-1];
                assign left_entry = cell_entry[gi-1];
                assign left_ins   = cell_ins[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_valid = 1'b0;
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_inner
                assign right_valid = cell_valid[gi+1];
                assign right_entry = cell_entry[gi+1];
            end

            sisp_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_valid  (left_valid),
                .left_entry  (left_entry),
                .left_ins    (left_ins),
                .right_valid (right_valid),
                .right_entry (right_entry),
                .valid       (cell_valid[gi]),
                .entry       (cell_entry[gi]),
                .ins         (cell_ins[gi])
            );
        end
    endgenerate

    // Load items until the batch end, then drain until the last pair leaves the head.
    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && full)
                begin
                    overflow_next = 1'b1;
                end
                if (in_accept && in_item.batch_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_accept && !cell_valid[1])
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    assign out_item.out_first  = cell_entry[0].first;
    assign out_item.out_second = cell_entry[0].second;
    assign out_item.out_last   = !cell_valid[1];
    assign out_item.overflowed = overflow_reg;

endmodule

// File: rtl/core/sisp_cell.sv
// One slot of the insertion chain: holds a pair and moves it to a neighbor.
module sisp_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sisp_pkg::cell_ctrl_t ctrl,
    input  logic               left_valid,
    input  sisp_pkg::entry_t   left_entry,
    input  logic               left_ins,
    input  logic               right_valid,
    input  sisp_pkg::entry_t   right_entry,
    output logic               valid,
    output sisp_pkg::entry_t   entry,
    output logic               ins
);
    import sisp_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    // This slot lies at or beyond the insertion point when it is empty or
    // holds a strictly larger sum, which keeps equal sums in arrival order.
    assign ins = !valid_reg || (pair_sum(entry_reg) > pair_sum(ctrl.new_entry));

    // Insert and shift-out never occur together; when neither occurs, the
    // slot simply holds.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.insert && ins)
        begin
            if (left_ins)
            begin
                valid_next = left_valid;
                entry_next = left_entry;
            end
            else
            begin
                valid_next = 1'b1;
                entry_next = ctrl.new_entry;
            end
        end
        else if (ctrl.shift_out)
        begin
            valid_next = right_valid;
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// File: tb/tb_stable_insertion_sort_pairs_by_sum_unit.sv
// Self-checking testbench for the stable pair sorter, with its scoreboard class.
module tb_stable_insertion_sort_pairs_by_sum_unit;

    import sisp_pkg::*;

    // The chain depth under test and a run limit that is far above the slowest
    // correct run (about 400 items and 400 results, each with long stalls).
    localparam int          CAPACITY    = 32;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // The scoreboard keeps its own sorted copy of the batch being loaded. Every
    // accepted item that fits is placed after all held pairs with an equal or
    // smaller sum, so ties keep their arrival order. On a batch-end item the whole
    // held list becomes the queue of results that must leave the block, in order.
    class pair_sort_scoreboard;
        int          depth;
        entry_t      held[$];
        logic        dropped;
        out_item_t   sorted_results[$];
        int unsigned results_checked;
        int unsigned mismatches;
        int unsigned batches;
        int unsigned overflow_batches;

        function new(int chain_depth);
            depth            = chain_depth;
            dropped          = 1'b0;
            results_checked  = 0;
            mismatches       = 0;
            batches          = 0;
            overflow_batches = 0;
        endfunction

        function int sum_of(entry_t e);
            return int'(e.first) + int'(e.second);
        endfunction

        function void note_item(in_item_t it);
            entry_t    e;
            out_item_t r;
            int        pos;
            e.first  = it.pip_first;
            e.second = it.pip_second;
            if (held.size() < depth)
            begin
                pos = held.size();
                while (pos > 0 && sum_of(held[pos-1]) > sum_of(e))
                    pos--;
                held.insert(pos, e);
            end
            else
                dropped = 1'b1;
            if (it.batch_end)
            begin
                foreach (held[k])
                begin
                    r.out_first  = held[k].first;
                    r.out_second = held[k].second;
                    r.out_last   = (k == held.size() - 1);
                    r.overflowed = dropped;
                    sorted_results.push_back(r);
                end
                batches++;
                if (dropped)
                    overflow_batches++;
                held.delete();
                dropped = 1'b0;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (sorted_results.size() == 0)
            begin
                $error("result with nothing pending: out_first %0d out_second %0d",
                       got.out_first, got.out_second);
                mismatches++;
                return;
            end
            want = sorted_results.pop_front();
            results_checked++;
            compare_field("out_first",  want.out_first,  got.out_first);
            compare_field("out_second", want.out_second, got.out_second);
            compare_field("out_last",   want.out_last,   got.out_last);
            compare_field("overflowed", want.overflowed, got.overflowed);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    pair_sort_scoreboard sb;

    // Chances, in percent, that the sender skips a cycle and that the
    // receiver holds off a result. They change from one phase to the next.
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned items_sent;
    int unsigned cycle_count;

    stable_insertion_sort_pairs_by_sum_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // All inputs hold known values from time zero on.
    initial
    begin
        sb             = new(CAPACITY);
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        cycle_count    = 0;
    end

    // The receiver takes or refuses each offered result at random.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // One monitor sees both channels at each edge, before the block's own
    // updates land, so the accepted item is noted before any result it causes
    // can be checked.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_item(in_item);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    // A hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one pair after an optional random gap and returns at the edge
    // where it is taken. When no gap is drawn, valid simply stays high.
    task automatic send_pair(input int a, input int b, input logic last_flag);
        in_item_t it;
        it.pip_first  = pip_t'(a);
        it.pip_second = pip_t'(b);
        it.batch_end  = last_flag;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // The sender goes quiet until every sorted result has left the block. The
    // first edge makes sure the monitor has already noted the last item.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.sorted_results.size() != 0)
            @(posedge clk);
    endtask

    // Short batches with known answers: the smallest and largest sums alone,
    // a run of equal sums that must keep arrival order, sums that arrive in
    // falling order so each new pair moves to the head, and small ties.
    task automatic run_directed();
        send_pair(0, 0, 1'b1);
        send_pair(7, 7, 1'b1);

        send_pair(3, 4, 1'b0);
        send_pair(7, 0, 1'b0);
        send_pair(0, 7, 1'b0);
        send_pair(1, 6, 1'b0);
        send_pair(0, 0, 1'b0);
        send_pair(7, 7, 1'b0);
        send_pair(2, 2, 1'b1);
        hold_until_drained();

        send_pair(7, 7, 1'b0);
        send_pair(6, 6, 1'b0);
        send_pair(5, 5, 1'b0);
        send_pair(0, 1, 1'b0);
        send_pair(0, 0, 1'b1);

        send_pair(1, 1, 1'b0);
        send_pair(2, 0, 1'b0);
        send_pair(0, 2, 1'b0);
        send_pair(1, 1, 1'b1);
        hold_until_drained();
    endtask

    // Random batches until the item goal is met. Most batches are short; the
    // second one has a fixed size that reaches the full chain or goes past it,
    // and a few take from 9 to CAPACITY + 4 pairs. Half the batches draw pips
    // from a narrow range so that many sums tie and stability is exercised.
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input int unsigned item_goal, input int unsigned big_size);
        int unsigned sent_here;
        int unsigned batch_no;
        int unsigned n;
        int          top;
        sent_here      = 0;
        batch_no       = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (sent_here < item_goal)
        begin
            if (batch_no == 1)
                n = big_size;
            else if ($urandom_range(19) == 0)
                n = $urandom_range(CAPACITY + 4, 9);
            else
                n = $urandom_range(8, 1);
            top = ($urandom_range(1) == 1) ? 7 : 2;
            for (int unsigned k = 0; k < n; k++)
                send_pair($urandom_range(top), $urandom_range(top), k == n - 1);
            sent_here += n;
            batch_no++;
            // Now and then the sender waits for the whole batch to drain.
            if ($urandom_range(7) == 0)
                hold_until_drained();
        end
        hold_until_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Phase sizes add up to about 350 items. The fixed big batches fill
        // the chain with the end marker on a dropped pair, fill it exactly,
        // and overrun it by several pairs before the end marker.
        run_phase(18, 59, 117, CAPACITY + 1);
        run_phase(59, 18, 117, CAPACITY);
        run_phase(0, 0, 117, CAPACITY + 6);

        hold_until_drained();
        // Any stray result after the drain would show up during this wait.
        repeat (CAPACITY + 8) @(posedge clk);

        $display("Sent %0d pairs in %0d batches, %0d of them past the chain depth of %0d.",
                 items_sent, sb.batches, sb.overflow_batches, CAPACITY);
        $display("Checked %0d sorted results under three idle and stall mixes.",
                 sb.results_checked);
        if (sb.mismatches == 0 && sb.sorted_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
